// ----- hw/rtl/running_mean_variance_min_max_assert.svh -----
// Assertion macros shared by the running statistics block.
`ifndef RUNNING_MEAN_VARIANCE_MIN_MAX_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_MIN_MAX_ASSERT_SVH

// Implication checked on every clock edge while out of reset.
`define RMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/rmv_pkg.sv -----
// Package: types and constants for the running statistics block.
`timescale 1ns / 1ps
`default_nettype none
package rmv_pkg;
  localparam int SmpW    = 16;
  localparam int CntW    = 16;
  localparam int SumW    = 32;
  localparam int SqW     = 47;
  localparam int MeanW   = 24;
  localparam int VarW    = 39;
  localparam int FracB   = 8;
  localparam int MaxCnt  = 65535;
  localparam int NumW    = 72;   // 2^8*(n*S2-S1^2) fits in 72 bits
  localparam int DenW    = 32;   // n*n
  localparam int DivW    = 72;   // divider dividend/quotient width

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   restart;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0]         sample_count;
    logic signed [MeanW-1:0] mean_q8;
    logic [VarW-1:0]         variance_q8;
    logic signed [SmpW-1:0]  smallest;
    logic signed [SmpW-1:0]  largest;
    logic                    overflowed;
  } out_item_t;

  // Snapshot of the statistics handed to the back end.
  typedef struct packed {
    logic [CntW-1:0]        cnt;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sq;
    logic signed [SmpW-1:0] mn;
    logic signed [SmpW-1:0] mx;
    logic                   ovf;
  } snap_t;
endpackage
`default_nettype wire

// ----- hw/rtl/running_mean_variance_min_max.sv -----
// Running count, mean, variance, min and max of a sample stream.
// Each accepted beat yields one result; the back end runs the mean and variance divisions
// in turn on a shared divider and takes the next snapshot once its result is popped.
// A two-beat snapshot queue lets the front end take beats while the back end works.
// Reset (rst_n low, synchronous) clears all statistics and empties all queues.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_min_max (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire rmv_pkg::in_item_t   in_data,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output rmv_pkg::out_item_t       out_data
);
  logic q_push, q_full, q_empty, q_pop;
  rmv_pkg::snap_t q_wdata, q_rdata;

  rmv_front u_front (.clk, .rst_n, .in_push, .in_full, .in_data,
                     .q_push, .q_full, .q_data(q_wdata));
  rmv_queue u_queue (.clk, .rst_n, .wr(q_push), .wdata(q_wdata), .full(q_full),
                     .rd(q_pop), .empty(q_empty), .rdata(q_rdata));
  rmv_back u_back (.clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop,
                   .out_empty, .out_pop, .out_data);
endmodule
`default_nettype wire

// ----- hw/rtl/rmv_front.sv -----
// Front end: accepts samples and updates count, sums, min, max, overflow.
`timescale 1ns / 1ps
`default_nettype none
module rmv_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire rmv_pkg::in_item_t in_data,
  output logic                 q_push,
  input  wire logic            q_full,
  output rmv_pkg::snap_t       q_data
);
  logic [rmv_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  logic signed [rmv_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [rmv_pkg::SqW-1:0]         sq_r, sq_nxt;
  logic signed [rmv_pkg::SmpW-1:0] mn_r, mn_nxt, mx_r, mx_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [rmv_pkg::CntW-1:0]        c0;
  logic signed [rmv_pkg::SumW-1:0] s0;
  logic [rmv_pkg::SqW-1:0]         q0;
  logic signed [rmv_pkg::SmpW-1:0] mn0, mx0;
  logic                            o0;
  logic signed [2*rmv_pkg::SmpW-1:0] prod;
  logic                            acc;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;
  assign prod    = in_data.sample * in_data.sample;

  always_comb begin
    c0 = in_data.restart ? '0 : cnt_r;
    s0 = in_data.restart ? '0 : sum_r;
    q0 = in_data.restart ? '0 : sq_r;
    mn0 = in_data.restart ? 16'sh7fff : mn_r;
    mx0 = in_data.restart ? 16'sh8000 : mx_r;
    o0 = in_data.restart ? 1'b0 : ovf_r;
    cnt_nxt = c0; sum_nxt = s0; sq_nxt = q0; mn_nxt = mn0; mx_nxt = mx0; ovf_nxt = o0;
    if (c0 < rmv_pkg::CntW'(rmv_pkg::MaxCnt)) begin
      cnt_nxt = c0 + 1'b1;
      sum_nxt = s0 + rmv_pkg::SumW'(in_data.sample);
      sq_nxt  = q0 + rmv_pkg::SqW'($unsigned(prod));
      if (in_data.sample < mn0) mn_nxt = in_data.sample;
      if (in_data.sample > mx0) mx_nxt = in_data.sample;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sum_r <= '0; sq_r <= '0;
      mn_r <= 16'sh7fff; mx_r <= 16'sh8000; ovf_r <= 1'b0;
    end else if (acc) begin
      cnt_r <= cnt_nxt; sum_r <= sum_nxt; sq_r <= sq_nxt;
      mn_r <= mn_nxt; mx_r <= mx_nxt; ovf_r <= ovf_nxt;
    end
  end

  assign q_push = acc;
  assign q_data = '{cnt: cnt_nxt, sum: sum_nxt, sq: sq_nxt, mn: mn_nxt, mx: mx_nxt,
                    ovf: ovf_nxt};
endmodule
`default_nettype wire

// ----- hw/rtl/rmv_queue.sv -----
// Two-entry queue of statistics snapshots between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module rmv_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr,
  input  wire rmv_pkg::snap_t wdata,
  output logic                full,
  input  wire logic           rd,
  output logic                empty,
  output rmv_pkg::snap_t      rdata
);
  rmv_pkg::snap_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] n_r;

  assign full  = (n_r == 2'd2);
  assign empty = (n_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; n_r <= '0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      n_r <= n_r + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rmv_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmv_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rmv_pkg::DivW-1:0]   num,
  input  wire logic [rmv_pkg::DenW-1:0]   den,
  output logic                            done,
  output logic [rmv_pkg::DivW-1:0]        quo
);
  logic [rmv_pkg::DivW-1:0] q_r;
  logic [rmv_pkg::DenW:0]   rem_r, trial;
  logic [rmv_pkg::DenW-1:0] d_r;
  logic [6:0]               k_r;
  logic                     busy_r;
  logic                     done_r;

  assign trial = {rem_r[rmv_pkg::DenW-1:0], q_r[rmv_pkg::DivW-1]};
  assign quo   = q_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; k_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; q_r <= num; d_r <= den; rem_r <= '0;
        k_r <= 7'(rmv_pkg::DivW);
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[rmv_pkg::DivW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[rmv_pkg::DivW-2:0], 1'b0};
        end
        k_r <= k_r - 1'b1;
        if (k_r == 7'd1) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rmv_back.sv -----
// Back end: forms mean and variance numerators and runs both divisions.
`timescale 1ns / 1ps
`default_nettype none
`include "running_mean_variance_min_max_assert.svh"
module rmv_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire rmv_pkg::snap_t q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output rmv_pkg::out_item_t  out_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_M4 = 4'd4, S_DM = 4'd5, S_WM = 4'd6, S_DV = 4'd7,
                         S_WV = 4'd8, S_OUT = 4'd9;
  logic [3:0] st_r;
  rmv_pkg::snap_t sn_r;
  logic [rmv_pkg::SumW-1:0] mag_r;
  logic [63:0] s1sq_r;
  logic [63:0] ns2_r;
  logic [rmv_pkg::DenW-1:0] nn_r;
  logic [rmv_pkg::MeanW-1:0] mean_r;
  logic [rmv_pkg::VarW-1:0] var_r;
  logic dv_start;
  logic [rmv_pkg::DivW-1:0] dv_num, dv_quo;
  logic [rmv_pkg::DenW-1:0] dv_den;
  logic dv_done;
  logic [rmv_pkg::DivW-1:0] diff;

  assign diff = rmv_pkg::DivW'(ns2_r - s1sq_r) << rmv_pkg::FracB;
  assign q_pop = (st_r == S_IDLE) && !q_empty;
  assign out_empty = (st_r != S_OUT);
  assign out_data = '{sample_count: sn_r.cnt, mean_q8: mean_r, variance_q8: var_r,
                      smallest: sn_r.mn, largest: sn_r.mx, overflowed: sn_r.ovf};

  always_comb begin
    dv_start = 1'b0;
    dv_num   = rmv_pkg::DivW'({mag_r, 8'd0});
    dv_den   = rmv_pkg::DenW'(sn_r.cnt);
    unique case (st_r)
      S_DM: dv_start = 1'b1;
      S_DV: begin
        dv_start = 1'b1; dv_num = diff; dv_den = nn_r;
      end
      default: dv_start = 1'b0;
    endcase
  end

  rmv_div u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                 .done(dv_done), .quo(dv_quo));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (!q_empty) begin
          sn_r <= q_data; st_r <= S_M1;
        end
        S_M1: begin
          mag_r <= sn_r.sum[rmv_pkg::SumW-1] ? 32'(-sn_r.sum) : 32'(sn_r.sum);
          nn_r  <= 32'(sn_r.cnt) * 32'(sn_r.cnt);
          st_r  <= S_M2;
        end
        S_M2: begin
          s1sq_r <= 64'(mag_r) * 64'(mag_r); st_r <= S_M3;
        end
        S_M3: begin
          ns2_r <= 64'(sn_r.sq[31:0]) * 64'(sn_r.cnt); st_r <= S_M4;
        end
        S_M4: begin
          ns2_r <= ns2_r + ((64'(sn_r.sq[rmv_pkg::SqW-1:32]) * 64'(sn_r.cnt)) << 32);
          st_r <= S_DM;
        end
        S_DM: st_r <= S_WM;
        S_WM: if (dv_done) begin
          mean_r <= sn_r.sum[rmv_pkg::SumW-1] ? -dv_quo[rmv_pkg::MeanW-1:0]
                                              : dv_quo[rmv_pkg::MeanW-1:0];
          st_r <= S_DV;
        end
        S_DV: st_r <= S_WV;
        S_WV: if (dv_done) begin
          var_r <= dv_quo[rmv_pkg::VarW-1:0]; st_r <= S_OUT;
        end
        S_OUT: if (out_pop) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `RMV_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE)
  `RMV_ASSERT_NEXT(a_hold_out, clk, rst_n, (st_r == S_OUT) && !out_pop, st_r == S_OUT)
  `RMV_ASSERT_IMP(a_cnt_nz, clk, rst_n, !out_empty, sn_r.cnt != '0)
endmodule
`default_nettype wire

// ----- sim/running_mean_variance_min_max_checker.sv -----
// Checker: predicts each result of the running statistics block and compares it.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_min_max_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic               in_full,
  input  wire rmv_pkg::in_item_t  in_data,
  input  wire logic               out_empty,
  input  wire logic               out_pop,
  input  wire rmv_pkg::out_item_t out_data,
  output int                      fail_count,
  output int                      stats_pending
);
  import rmv_pkg::*;

  // predictor state
  int unsigned            acc_count;
  longint                 acc_sum;
  longint                 acc_sq;
  logic signed [SmpW-1:0] acc_min;
  logic signed [SmpW-1:0] acc_max;
  logic                   acc_dropped;

  out_item_t stats_queue[$];

  function automatic void clear_stats();
    acc_count   = 0;
    acc_sum     = 0;
    acc_sq      = 0;
    acc_min     = 16'sh7fff;
    acc_max     = 16'sh8000;
    acc_dropped = 1'b0;
  endfunction

  function automatic out_item_t fold_sample(in_item_t beat);
    out_item_t    res;
    longint       smp;
    longint       mag;
    longint       mean;
    logic [127:0] num;
    logic [127:0] quo;
    smp = longint'(beat.sample);
    if (beat.restart) clear_stats();
    if (acc_count < MaxCnt) begin
      acc_count++;
      acc_sum += smp;
      acc_sq  += smp * smp;
      if (beat.sample < acc_min) acc_min = beat.sample;
      if (beat.sample > acc_max) acc_max = beat.sample;
    end else begin
      acc_dropped = 1'b1;
    end
    mag  = (acc_sum < 0) ? -acc_sum : acc_sum;
    mean = (mag <<< FracB) / longint'(acc_count);
    if (acc_sum < 0) mean = -mean;
    if (mean > 8388607) mean = 8388607;
    if (mean < -8388608) mean = -8388608;
    num = ((128'(acc_count) * 128'(acc_sq)) - (128'(mag) * 128'(mag))) << FracB;
    quo = num / (128'(acc_count) * 128'(acc_count));
    res.sample_count = acc_count[CntW-1:0];
    res.mean_q8      = mean[MeanW-1:0];
    res.variance_q8  = (quo > {VarW{1'b1}}) ? {VarW{1'b1}} : quo[VarW-1:0];
    res.smallest     = acc_min;
    res.largest      = acc_max;
    res.overflowed   = acc_dropped;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_stats();
      stats_queue.delete();
      fail_count = 0;
    end else begin
      if (in_push && !in_full) stats_queue.push_back(fold_sample(in_data));
      if (out_pop && !out_empty) begin
        if (stats_queue.size() == 0) begin
          $error("result beat with no expected result");
          fail_count++;
        end else begin
          want = stats_queue.pop_front();
          if (out_data.sample_count !== want.sample_count) begin
            $error("sample_count exp %0d got %0d", want.sample_count, out_data.sample_count);
            fail_count++;
          end
          if (out_data.mean_q8 !== want.mean_q8) begin
            $error("mean_q8 exp %0d got %0d", want.mean_q8, out_data.mean_q8);
            fail_count++;
          end
          if (out_data.variance_q8 !== want.variance_q8) begin
            $error("variance_q8 exp %0d got %0d", want.variance_q8, out_data.variance_q8);
            fail_count++;
          end
          if (out_data.smallest !== want.smallest) begin
            $error("smallest exp %0d got %0d", want.smallest, out_data.smallest);
            fail_count++;
          end
          if (out_data.largest !== want.largest) begin
            $error("largest exp %0d got %0d", want.largest, out_data.largest);
            fail_count++;
          end
          if (out_data.overflowed !== want.overflowed) begin
            $error("overflowed exp %0b got %0b", want.overflowed, out_data.overflowed);
            fail_count++;
          end
        end
      end
    end
    stats_pending = stats_queue.size();
  end

  initial begin
    fail_count    = 0;
    stats_pending = 0;
  end
endmodule
`default_nettype wire

// ----- sim/running_mean_variance_min_max_tb.sv -----
// Testbench top: drives samples and pops results of the running statistics block.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_min_max_tb;
  import rmv_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;
  int        fail_count;
  int        stats_pending;

  // sender gaps off while set; receiver mode flips on its own
  bit        send_no_gaps;
  bit        pop_no_gaps;
  int        pop_total;

  running_mean_variance_min_max dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  running_mean_variance_min_max_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .fail_count(fail_count), .stats_pending(stats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a run of about 1050 beats; reaching it reports a failure.
  initial begin
    #20_000_000;
    $display("FAIL running_mean_variance_min_max");
    $finish;
  end

  // Offer one sample beat; hold push until accepted, then idle a random gap.
  task automatic send_sample(input logic signed [SmpW-1:0] smp, input logic rst_stats);
    int gap;
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= '{sample: smp, restart: rst_stats};
    do @(posedge clk); while (in_full);
    gap = send_no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (stats_pending != 0) @(posedge clk);
  endtask

  // Random sample: mostly full range, sometimes extremes or near zero.
  function automatic logic signed [SmpW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SmpW'(int'($urandom_range(0, 15)) - 8);
      default: return SmpW'($urandom);
    endcase
  endfunction

  // Receiver: random pop gaps, quiet stretches, and one long hold-off so the
  // block fills up and backs up its input.
  initial begin
    int gap;
    gap       = 0;
    pop_total = 0;
    out_pop   = 1'b0;
    pop_no_gaps = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      out_pop <= (gap == 0);
      if (gap > 0) gap--;
      @(posedge clk);
      if (out_pop && !out_empty) begin
        pop_total++;
        if (pop_total % 100 == 0) pop_no_gaps = ~pop_no_gaps;
        gap = pop_no_gaps ? 0 : $urandom_range(0, 14);
        if (pop_total == 40) gap = 3000;
      end
    end
  end

  initial begin
    int run_len;
    in_push = 1'b0;
    in_data = '0;
    send_no_gaps = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, sign handling, restart
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b1);   // restart on the most negative value
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b0);
    send_sample(-16'sd3, 1'b1);     // mean with truncation toward zero
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(16'sd7, 1'b1);
    drain_results();

    // random runs between restarts; many short runs, a few long ones
    repeat (81) begin
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_no_gaps = ($urandom_range(0, 3) == 0);
      send_sample(pick_sample(), 1'b1);
      repeat (run_len - 1) send_sample(pick_sample(), $urandom_range(0, 49) == 0);
    end
    send_no_gaps = 1'b0;
    drain_results();

    // short tail with occasional restarts
    send_sample(16'sh1234, 1'b1);
    repeat (30) send_sample(pick_sample(), $urandom_range(0, 9) == 0);

    // wait for the tail, then let the block idle before the final check
    drain_results();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && stats_pending == 0) begin
      $display("PASS running_mean_variance_min_max");
    end else begin
      $display("FAIL running_mean_variance_min_max");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- running_mean_variance_min_max.f -----
+incdir+hw/rtl
hw/rtl/rmv_pkg.sv
hw/rtl/rmv_front.sv
hw/rtl/rmv_queue.sv
hw/rtl/rmv_div.sv
hw/rtl/rmv_back.sv
hw/rtl/running_mean_variance_min_max.sv
sim/running_mean_variance_min_max_checker.sv
sim/running_mean_variance_min_max_tb.sv
